>>> rtl/core/capped_step_toward_target_3d_unit_defines.svh
// Assertion macros shared by the capped step unit.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef CAPPED_STEP_TOWARD_TARGET_3D_UNIT_DEFINES_SVH
`define CAPPED_STEP_TOWARD_TARGET_3D_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CST3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CST3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cst3_pkg.sv
// Types and constants of the capped step toward target unit.
// No dependencies; used by the channel interfaces and the top level.
package cst3_pkg;

    localparam int POS_W   = 21;
    localparam int STEP_W  = 20;
    localparam int BAND_W  = 20;
    localparam int LIFT_W  = 21;
    localparam int JOINT_W = 23;
    localparam int CFG_W   = 21;
    localparam int MAG_W   = 21;
    localparam int PROD_W  = 42;
    localparam int SQ_W    = 40;
    localparam int D2_W    = 44;
    localparam int ROOT_W  = 22;
    localparam int QUO_W   = 20;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(5);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W);

    localparam logic [D2_W-1:0] SQRT_BIT0 = D2_W'(1) << (D2_W - 2);

    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(50000);
    localparam logic [BAND_W-1:0] BAND_RST = BAND_W'(1000);
    localparam logic [LIFT_W-1:0] LIFT_RST = LIFT_W'(450000);
    localparam logic signed [POS_W-1:0] Z_RST = POS_W'(100000);

    localparam logic [1:0] CFG_STEP_LENGTH = 2'd0;
    localparam logic [1:0] CFG_DEAD_BAND   = 2'd1;
    localparam logic [1:0] CFG_LIFT_OFFSET = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_DECIDE,
        S_SQRT,
        S_MULQ,
        S_DIV,
        S_APPLY,
        S_FIN
    } t_state;

endpackage

>>> rtl/core/cst3_target_if.sv
// Input channel: commanded target point with valid/ready handshake.
// Depends on cst3_pkg for field widths.
interface cst3_target_if
    import cst3_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

>>> rtl/core/cst3_result_if.sv
// Output channel: new position, lift joint and moved flag with valid/ready.
// Depends on cst3_pkg for field widths.
interface cst3_result_if
    import cst3_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [JOINT_W-1:0] lift_joint;
    logic                      moved;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output lift_joint, output moved, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input lift_joint, input moved, output ready);
endinterface

>>> rtl/core/capped_step_toward_target_3d_unit.sv
// Capped step toward target: one shared multiplier, sqrt and divider under a sequencer.
// Depends on cst3_pkg, cst3_target_if, cst3_result_if and the defines header.
//
//   channel    dir   handshake            payload
//   i_target   in    valid/ready          target_x, target_y, target_z
//   o_result   out   valid/ready          pos_x, pos_y, pos_z, lift_joint, moved
//   i_cfg_*    in    i_cfg_we only        i_cfg_idx, i_cfg_data
//
// An item inside the dead band and one that lands on the target pass the squares and
// the decide state; a capped step adds 22 sqrt iterations and per axis one
// multiply, a divide (load plus 20 quotient bits) and one apply. The squares run on
// the shared multiplier. Reset (synchronous, active low) restores the control and
// configuration registers and puts the tool at 0,0,100000.
// A result stalled at o_result holds the sequencer in its final state only.
`include "capped_step_toward_target_3d_unit_defines.svh"

module capped_step_toward_target_3d_unit
    import cst3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    cst3_target_if.sink      i_target,
    cst3_result_if.source    o_result
);

    t_state r_state, n_state;

    logic [STEP_W-1:0] r_step;
    logic [BAND_W-1:0] r_band;
    logic [LIFT_W-1:0] r_lift;

    logic signed [POS_W-1:0] r_cur_x, r_cur_y, r_cur_z;
    logic signed [POS_W-1:0] r_tx, r_ty, r_tz;
    logic [MAG_W-1:0]        r_mag [0:2];
    logic                    r_neg [0:2];

    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_axis;
    logic [PROD_W-1:0] r_prod;
    logic [D2_W-1:0]   r_d2;
    logic [SQ_W-1:0]   r_band2, r_step2;
    logic              r_moved;

    logic [D2_W-1:0]   r_sq_n, r_root, r_bit;
    logic [ROOT_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_dvd_lo;
    logic [QUO_W-1:0]  r_quo;

    logic                      r_out_valid;
    logic signed [POS_W-1:0]   r_out_x, r_out_y, r_out_z;
    logic signed [JOINT_W-1:0] r_out_joint;
    logic                      r_out_moved;

    logic              s_accept, s_out_load;
    logic [MAG_W-1:0]  s_mul_a, s_mul_b;
    logic [PROD_W-1:0] s_prod;
    logic [MAG_W-1:0]  s_axis_mag;
    logic              s_axis_neg;
    logic [D2_W:0]     s_sqrt_try;
    logic              s_sqrt_ge;
    logic [ROOT_W:0]   s_div_part;
    logic [ROOT_W:0]   s_div_diff;
    logic signed [POS_W:0] s_dx, s_dy, s_dz;
    logic signed [POS_W-1:0] s_step_val;

    assign s_accept   = i_target.valid && i_target.ready;
    assign s_out_load = (r_state == S_FIN) && (!r_out_valid || o_result.ready);

    // Per-axis differences at the input transfer
    assign s_dx = (POS_W+1)'(i_target.target_x) - (POS_W+1)'(r_cur_x);
    assign s_dy = (POS_W+1)'(i_target.target_y) - (POS_W+1)'(r_cur_y);
    assign s_dz = (POS_W+1)'(i_target.target_z) - (POS_W+1)'(r_cur_z);

    always_comb begin
        case (r_axis)
            AXIS_X:  begin s_axis_mag = r_mag[0]; s_axis_neg = r_neg[0]; end
            AXIS_Y:  begin s_axis_mag = r_mag[1]; s_axis_neg = r_neg[1]; end
            AXIS_Z:  begin s_axis_mag = r_mag[2]; s_axis_neg = r_neg[2]; end
            default: begin s_axis_mag = r_mag[2]; s_axis_neg = r_neg[2]; end
        endcase
    end

    // Shared arithmetic: one multiplier, the sqrt trial and the divide trial
    assign s_prod     = PROD_W'(s_mul_a) * PROD_W'(s_mul_b);
    assign s_sqrt_try = (D2_W+1)'(r_root) + (D2_W+1)'(r_bit);
    assign s_sqrt_ge  = (D2_W+1)'(r_sq_n) >= s_sqrt_try;
    assign s_div_part = {r_rem, r_dvd_lo[QUO_W-1]};
    assign s_div_diff = s_div_part - (ROOT_W+1)'(r_root[ROOT_W-1:0]);
    assign s_step_val = s_axis_neg ? -POS_W'(r_quo) : POS_W'(r_quo);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_accept) n_state = S_SQ;
            S_SQ:     if (r_cnt == SQ_LAST) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_d2 <= D2_W'(r_band2) || r_d2 <= D2_W'(r_step2)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT:   if (r_cnt == SQRT_LAST) n_state = S_MULQ;
            S_MULQ:   n_state = S_DIV;
            S_DIV:    if (r_cnt == DIV_LAST) n_state = S_APPLY;
            S_APPLY:  n_state = (r_axis == AXIS_Z) ? S_FIN : S_MULQ;
            S_FIN:    if (s_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand select
    always_comb begin
        i_target.ready = 1'b0;
        s_mul_a        = s_axis_mag;
        s_mul_b        = MAG_W'(r_step);
        case (r_state)
            S_IDLE: i_target.ready = 1'b1;
            S_SQ: begin
                case (r_cnt)
                    CNT_W'(0): begin s_mul_a = r_mag[0]; s_mul_b = r_mag[0]; end
                    CNT_W'(1): begin s_mul_a = r_mag[1]; s_mul_b = r_mag[1]; end
                    CNT_W'(2): begin s_mul_a = r_mag[2]; s_mul_b = r_mag[2]; end
                    CNT_W'(3): begin
                        s_mul_a = MAG_W'(r_band);
                        s_mul_b = MAG_W'(r_band);
                    end
                    default: begin
                        s_mul_a = MAG_W'(r_step);
                        s_mul_b = MAG_W'(r_step);
                    end
                endcase
            end
            default: begin
                s_mul_a = s_axis_mag;
                s_mul_b = MAG_W'(r_step);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_RST;
            r_band      <= BAND_RST;
            r_lift      <= LIFT_RST;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_cur_z     <= Z_RST;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_axis      <= AXIS_X;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP_LENGTH: r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_DEAD_BAND:   r_band <= i_cfg_data[BAND_W-1:0];
                    CFG_LIFT_OFFSET: r_lift <= i_cfg_data[LIFT_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    r_cnt  <= '0;
                    r_axis <= AXIS_X;
                end
                S_SQ:     r_cnt <= r_cnt + CNT_W'(1);
                S_DECIDE: begin
                    r_cnt <= '0;
                    // Inside the step length: land on the target
                    if (r_d2 > D2_W'(r_band2) && r_d2 <= D2_W'(r_step2)) begin
                        r_cur_x <= r_tx;
                        r_cur_y <= r_ty;
                        r_cur_z <= r_tz;
                    end
                end
                S_SQRT:   r_cnt <= (r_cnt == SQRT_LAST) ? '0 : r_cnt + CNT_W'(1);
                S_MULQ:   r_cnt <= '0;
                S_DIV:    r_cnt <= r_cnt + CNT_W'(1);
                S_APPLY: begin
                    r_axis <= r_axis + 2'd1;
                    case (r_axis)
                        AXIS_X:  r_cur_x <= r_cur_x + s_step_val;
                        AXIS_Y:  r_cur_y <= r_cur_y + s_step_val;
                        default: r_cur_z <= r_cur_z + s_step_val;
                    endcase
                end
                default: ;
            endcase

            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_prod <= s_prod;

        if (s_accept) begin
            r_tx     <= i_target.target_x;
            r_ty     <= i_target.target_y;
            r_tz     <= i_target.target_z;
            r_neg[0] <= s_dx[POS_W];
            r_neg[1] <= s_dy[POS_W];
            r_neg[2] <= s_dz[POS_W];
            r_mag[0] <= s_dx[POS_W] ? MAG_W'(-s_dx) : MAG_W'(s_dx);
            r_mag[1] <= s_dy[POS_W] ? MAG_W'(-s_dy) : MAG_W'(s_dy);
            r_mag[2] <= s_dz[POS_W] ? MAG_W'(-s_dz) : MAG_W'(s_dz);
            r_d2     <= '0;
        end

        case (r_state)
            S_SQ: begin
                // Product of the previous cycle lands here
                case (r_cnt)
                    CNT_W'(1), CNT_W'(2), CNT_W'(3): r_d2 <= r_d2 + D2_W'(r_prod);
                    CNT_W'(4): r_band2 <= r_prod[SQ_W-1:0];
                    CNT_W'(5): r_step2 <= r_prod[SQ_W-1:0];
                    default: ;
                endcase
            end
            S_DECIDE: begin
                r_moved <= r_d2 > D2_W'(r_band2);
                r_sq_n  <= r_d2;
                r_root  <= '0;
                r_bit   <= SQRT_BIT0;
            end
            S_SQRT: begin
                if (s_sqrt_ge) begin
                    r_sq_n <= r_sq_n - D2_W'(s_sqrt_try);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    // Quotient fits QUO_W bits, so the high part starts below the root
                    r_rem    <= ROOT_W'(r_prod[PROD_W-2:QUO_W]);
                    r_dvd_lo <= r_prod[QUO_W-1:0];
                    r_quo    <= '0;
                end else begin
                    if (!s_div_diff[ROOT_W]) begin
                        r_rem <= s_div_diff[ROOT_W-1:0];
                        r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem <= s_div_part[ROOT_W-1:0];
                        r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                    r_dvd_lo <= {r_dvd_lo[QUO_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase

        if (s_out_load) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_z     <= r_cur_z;
            r_out_joint <= JOINT_W'(r_lift) - JOINT_W'(r_cur_z);
            r_out_moved <= r_moved;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.pos_x      = r_out_x;
    assign o_result.pos_y      = r_out_y;
    assign o_result.pos_z      = r_out_z;
    assign o_result.lift_joint = r_out_joint;
    assign o_result.moved      = r_out_moved;

    `CST3_ASSERT_NEXT(a_accept_starts_sq, i_clk, i_rst_n, s_accept, r_state == S_SQ, "transfer in did not start the squares")
    `CST3_ASSERT_NOW(a_div_rem_below_root, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt != '0), r_rem < r_root[ROOT_W-1:0], "divider remainder not below root")
    `CST3_ASSERT_NOW(a_quo_capped, i_clk, i_rst_n, r_state == S_APPLY, r_quo <= r_step, "axis advance exceeds step length")
    `CST3_ASSERT_NEXT(a_stall_holds_fin, i_clk, i_rst_n, (r_state == S_FIN) && r_out_valid && !o_result.ready, r_state == S_FIN, "finished item left while output stalled")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench of capped_step_toward_target_3d_unit: directed and random targets checked
// against an in-bench model of the capped move, with random stalls on both channels.
// Depends on cst3_pkg, cst3_target_if and cst3_result_if.
module tb;
    import cst3_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 800000;
    localparam int TAIL_CYCLES = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int CHUNK_ITEMS = 90;
    localparam longint FIELD_MIN = -1048576;
    localparam longint FIELD_MAX = 1048575;

    typedef struct {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [JOINT_W-1:0] lift_joint;
        logic                      moved;
    } t_pose;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    cst3_target_if tgt ();
    cst3_result_if res ();

    capped_step_toward_target_3d_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_target   (tgt.sink),
        .o_result   (res.source)
    );

    // Tool position and register copies of the model
    longint tool_x, tool_y, tool_z;
    longint step_len, band, lift_ofs;

    t_pose expected_poses[$];
    int    errors = 0;
    int    cycles = 0;
    int    send_idle_pct;
    int    recv_idle_pct;
    logic  hold_rx;

    always #6 i_clk = ~i_clk;

    function automatic longint floor_root(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = ROOT_W; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) root = trial;
        end
        return root;
    endfunction

    // Advance the tool for one accepted target and queue the pose it yields.
    task automatic step_tool(input logic signed [POS_W-1:0] tx, ty, tz);
        longint dx, dy, dz, dist2, root;
        t_pose  p;
        dx = longint'(tx) - tool_x;
        dy = longint'(ty) - tool_y;
        dz = longint'(tz) - tool_z;
        dist2 = dx * dx + dy * dy + dz * dz;
        p.moved = dist2 > band * band;
        if (p.moved) begin
            if (dist2 <= step_len * step_len) begin
                tool_x = tx;
                tool_y = ty;
                tool_z = tz;
            end else begin
                root = floor_root(dist2);
                // signed division truncates toward zero
                tool_x += dx * step_len / root;
                tool_y += dy * step_len / root;
                tool_z += dz * step_len / root;
            end
        end
        p.pos_x      = POS_W'(tool_x);
        p.pos_y      = POS_W'(tool_y);
        p.pos_z      = POS_W'(tool_z);
        p.lift_joint = JOINT_W'(lift_ofs - tool_z);
        expected_poses.insert(expected_poses.size(), p);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_STEP_LENGTH: step_len = data[STEP_W-1:0];
            CFG_DEAD_BAND:   band     = data[BAND_W-1:0];
            CFG_LIFT_OFFSET: lift_ofs = data[LIFT_W-1:0];
            default: ;  // drop writes to the unused index
        endcase
    endtask

    task automatic set_config(input longint s, input longint b, input longint l);
        write_reg(CFG_STEP_LENGTH, CFG_W'(s));
        write_reg(CFG_DEAD_BAND, CFG_W'(b));
        write_reg(CFG_LIFT_OFFSET, CFG_W'(l));
    endtask

    // Offer one target; return at the edge of its transfer with valid still high.
    task automatic send_target(input logic signed [POS_W-1:0] tx, ty, tz);
        while ($urandom_range(99) < send_idle_pct) begin
            tgt.valid <= 1'b0;
            @(posedge i_clk);
        end
        tgt.valid    <= 1'b1;
        tgt.target_x <= tx;
        tgt.target_y <= ty;
        tgt.target_z <= tz;
        @(posedge i_clk);
        while (!tgt.ready) @(posedge i_clk);
        step_tool(tx, ty, tz);
    endtask

    task automatic wait_idle();
        tgt.valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [POS_W-1:0] near(input longint center, input longint span);
        longint v;
        v = center + longint'($urandom_range(2 * span)) - span;
        if (v < FIELD_MIN) v = FIELD_MIN;
        if (v > FIELD_MAX) v = FIELD_MAX;
        return POS_W'(v);
    endfunction

    task automatic pick_target(output logic signed [POS_W-1:0] tx, ty, tz);
        int     mode;
        longint span;
        mode = $urandom_range(99);
        if (mode < 25) begin
            // any 21-bit pattern, out of range ones included
            tx = POS_W'($urandom);
            ty = POS_W'($urandom);
            tz = POS_W'($urandom);
        end else if (mode < 60) begin
            tx = near(0, 1000000);
            ty = near(0, 1000000);
            tz = near(0, 1000000);
        end else if (mode < 85) begin
            span = step_len + band + 1;
            if (span > 1000000) span = 1000000;
            tx = near(tool_x, span);
            ty = near(tool_y, span);
            tz = near(tool_z, span);
        end else begin
            // inside the dead band
            span = band / 2;
            if (span > 1000000) span = 1000000;
            tx = near(tool_x, span);
            ty = near(tool_y, span);
            tz = near(tool_z, span);
        end
    endtask

    task automatic random_config();
        longint s, b, l;
        case ($urandom_range(5))
            0: s = $urandom_range(1, 2000);
            1, 2: s = $urandom_range(2000, 200000);
            3: s = $urandom_range(200000, 1000000);
            4: s = $urandom_range(0, 1) ? 0 : 1000000;
            default: s = CFG_W'($urandom);
        endcase
        case ($urandom_range(4))
            0: b = 0;
            1, 2: b = $urandom_range(1, 5000);
            3: b = $urandom_range(5000, 60000);
            default: b = $urandom_range(0, 3) == 0 ? CFG_W'($urandom) : 1000;
        endcase
        l = $urandom_range(0, 3) == 0 ? CFG_W'($urandom) : $urandom_range(0, 2000000);
        set_config(s, b, l);
    endtask

    task automatic test_reset_config();
        send_target(0, 0, 100000);                 // already on target
        send_target(1000, 0, 100000);              // exactly on the dead band edge
        send_target(0, 0, 101001);                 // just outside, lands
        send_target(0, 50000, 101001);             // distance equals step length
        send_target(1000000, -1000000, 1000000);   // capped step
        send_target(-1048576, -1048576, -1048576); // out of range, most negative
        send_target(1048575, 1048575, 1048575);    // out of range, most positive
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_STEP_LENGTH, '0);
        send_target(-1000000, 1000000, -1000000);  // decided move with zero step
        wait_idle();
        write_reg(CFG_STEP_LENGTH, CFG_W'(1));
        send_target(1048575, 7, -3);               // truncation keeps small axes still
        wait_idle();
        set_config(FIELD_MAX + FIELD_MAX + 1, 0, 0);
        send_target(-1000000, 1000000, -1000000);
        send_target(-1000000, 1000000, -1000000);
        send_target(-999999, 1000000, -1000000);
        wait_idle();
        set_config(1000000, FIELD_MAX + FIELD_MAX + 1, 2000000);
        send_target(0, 0, 0);
        send_target(1048575, -1048576, 1048575);
        wait_idle();
        set_config(1000000, 1000000, FIELD_MAX + FIELD_MAX + 1);
        send_target(1048575, -1048576, -1048576);
        wait_idle();
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        send_target(-5, 1000000, 12345);
        wait_idle();
        set_config(STEP_RST, BAND_RST, LIFT_RST);
        send_target(0, 0, 100000);
        wait_idle();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct);
        logic signed [POS_W-1:0] tx, ty, tz;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (4) begin
            random_config();
            repeat (CHUNK_ITEMS) begin
                pick_target(tx, ty, tz);
                send_target(tx, ty, tz);
            end
            wait_idle();
        end
    endtask

    // Hold the result channel off while targets keep coming, so the input stalls.
    task automatic test_backpressure();
        logic signed [POS_W-1:0] tx, ty, tz;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(50000, 1000, 450000);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
            begin
                repeat (24) begin
                    pick_target(tx, ty, tz);
                    send_target(tx, ty, tz);
                end
            end
        join
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        res.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_poses.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %0d %0d %0d",
                         $time, res.pos_x, res.pos_y, res.pos_z);
                errors++;
            end else begin
                want = expected_poses.pop_front();
                check_field("pos_x", want.pos_x, res.pos_x);
                check_field("pos_y", want.pos_y, res.pos_y);
                check_field("pos_z", want.pos_z, res.pos_z);
                check_field("lift_joint", want.lift_joint, res.lift_joint);
                check_field("moved", want.moved, res.moved);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_poses.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_STEP_LENGTH;
        i_cfg_data   = '0;
        tgt.valid    = 1'b0;
        tgt.target_x = '0;
        tgt.target_y = '0;
        tgt.target_z = '0;
        res.ready    = 1'b0;
        hold_rx      = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 50;
        tool_x   = 0;
        tool_y   = 0;
        tool_z   = Z_RST;
        step_len = STEP_RST;
        band     = BAND_RST;
        lift_ofs = LIFT_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_config_extremes();
        test_random_phase(33, 50);
        test_random_phase(50, 33);
        test_random_phase(0, 0);
        test_backpressure();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
